// File: design/s512_pkg.sv
package s512_pkg;

    typedef struct packed {
        logic [63:0] message_word;
        logic        first_block;
        logic        last_block;
    } t_in_word;

    typedef struct packed {
        logic [63:0] hash_word;
        logic [2:0]  hash_index;
        logic        final_word;
    } t_out_word;

    // one block handed from the word collector to the round engine
    typedef struct packed {
        logic [1023:0] words;
        logic          reload;
        logic          variant;
        logic          last;
    } t_blk;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_eng_state;

    localparam int NumRounds = 80;

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        begin
            case (t)
                7'd0: k = 64'h428A2F98D728AE22; 7'd1: k = 64'h7137449123EF65CD;
                7'd2: k = 64'hB5C0FBCFEC4D3B2F; 7'd3: k = 64'hE9B5DBA58189DBBC;
                7'd4: k = 64'h3956C25BF348B538; 7'd5: k = 64'h59F111F1B605D019;
                7'd6: k = 64'h923F82A4AF194F9B; 7'd7: k = 64'hAB1C5ED5DA6D8118;
                7'd8: k = 64'hD807AA98A3030242; 7'd9: k = 64'h12835B0145706FBE;
                7'd10: k = 64'h243185BE4EE4B28C; 7'd11: k = 64'h550C7DC3D5FFB4E2;
                7'd12: k = 64'h72BE5D74F27B896F; 7'd13: k = 64'h80DEB1FE3B1696B1;
                7'd14: k = 64'h9BDC06A725C71235; 7'd15: k = 64'hC19BF174CF692694;
                7'd16: k = 64'hE49B69C19EF14AD2; 7'd17: k = 64'hEFBE4786384F25E3;
                7'd18: k = 64'h0FC19DC68B8CD5B5; 7'd19: k = 64'h240CA1CC77AC9C65;
                7'd20: k = 64'h2DE92C6F592B0275; 7'd21: k = 64'h4A7484AA6EA6E483;
                7'd22: k = 64'h5CB0A9DCBD41FBD4; 7'd23: k = 64'h76F988DA831153B5;
                7'd24: k = 64'h983E5152EE66DFAB; 7'd25: k = 64'hA831C66D2DB43210;
                7'd26: k = 64'hB00327C898FB213F; 7'd27: k = 64'hBF597FC7BEEF0EE4;
                7'd28: k = 64'hC6E00BF33DA88FC2; 7'd29: k = 64'hD5A79147930AA725;
                7'd30: k = 64'h06CA6351E003826F; 7'd31: k = 64'h142929670A0E6E70;
                7'd32: k = 64'h27B70A8546D22FFC; 7'd33: k = 64'h2E1B21385C26C926;
                7'd34: k = 64'h4D2C6DFC5AC42AED; 7'd35: k = 64'h53380D139D95B3DF;
                7'd36: k = 64'h650A73548BAF63DE; 7'd37: k = 64'h766A0ABB3C77B2A8;
                7'd38: k = 64'h81C2C92E47EDAEE6; 7'd39: k = 64'h92722C851482353B;
                7'd40: k = 64'hA2BFE8A14CF10364; 7'd41: k = 64'hA81A664BBC423001;
                7'd42: k = 64'hC24B8B70D0F89791; 7'd43: k = 64'hC76C51A30654BE30;
                7'd44: k = 64'hD192E819D6EF5218; 7'd45: k = 64'hD69906245565A910;
                7'd46: k = 64'hF40E35855771202A; 7'd47: k = 64'h106AA07032BBD1B8;
                7'd48: k = 64'h19A4C116B8D2D0C8; 7'd49: k = 64'h1E376C085141AB53;
                7'd50: k = 64'h2748774CDF8EEB99; 7'd51: k = 64'h34B0BCB5E19B48A8;
                7'd52: k = 64'h391C0CB3C5C95A63; 7'd53: k = 64'h4ED8AA4AE3418ACB;
                7'd54: k = 64'h5B9CCA4F7763E373; 7'd55: k = 64'h682E6FF3D6B2B8A3;
                7'd56: k = 64'h748F82EE5DEFB2FC; 7'd57: k = 64'h78A5636F43172F60;
                7'd58: k = 64'h84C87814A1F0AB72; 7'd59: k = 64'h8CC702081A6439EC;
                7'd60: k = 64'h90BEFFFA23631E28; 7'd61: k = 64'hA4506CEBDE82BDE9;
                7'd62: k = 64'hBEF9A3F7B2C67915; 7'd63: k = 64'hC67178F2E372532B;
                7'd64: k = 64'hCA273ECEEA26619C; 7'd65: k = 64'hD186B8C721C0C207;
                7'd66: k = 64'hEADA7DD6CDE0EB1E; 7'd67: k = 64'hF57D4F7FEE6ED178;
                7'd68: k = 64'h06F067AA72176FBA; 7'd69: k = 64'h0A637DC5A2C898A6;
                7'd70: k = 64'h113F9804BEF90DAE; 7'd71: k = 64'h1B710B35131C471B;
                7'd72: k = 64'h28DB77F523047D84; 7'd73: k = 64'h32CAAB7B40C72493;
                7'd74: k = 64'h3C9EBE0A15C9BEBC; 7'd75: k = 64'h431D67C49C100D4C;
                7'd76: k = 64'h4CC5D4BECB3E42B6; 7'd77: k = 64'h597F299CFC657E2A;
                7'd78: k = 64'h5FCB6FAB3AD6FAEC; 7'd79: k = 64'h6C44198C4A475817;
                default: k = '0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [511:0] init_hash(input logic sel);
        begin
            if (sel) begin
                return {64'h47B5481DBEFA4FA4, 64'hDB0C2E0D64F98FA7,
                        64'h8EB44A8768581511, 64'h67332667FFC00B31,
                        64'h152FECD8F70E5939, 64'h9159015A3070DD17,
                        64'h629A292A367CD507, 64'hCBBB9D5DC1059ED8};
            end
            return {64'h5BE0CD19137E2179, 64'h1F83D9ABFB41BD6B,
                    64'h9B05688C2B3E6C1F, 64'h510E527FADE682D1,
                    64'hA54FF53A5F1D36F1, 64'h3C6EF372FE94F82B,
                    64'hBB67AE8584CAA73B, 64'h6A09E667F3BCC908};
        end
    endfunction

endpackage

// File: design/s512_front.sv
module s512_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  s512_pkg::t_in_word i_word,
    input  logic             i_push,
    output logic             o_full,
    input  logic             i_variant,
    output s512_pkg::t_blk   o_blk,
    output logic             o_blk_valid,
    input  logic             i_blk_take
);
    import s512_pkg::*;

    logic [1023:0] r_words;
    logic [3:0]    r_count;
    logic          r_reload;
    logic          r_var;
    logic          r_last;
    logic          r_valid;
    logic          w_acc;

    // the collected block waits in r_words until the engine takes it
    assign o_full      = r_valid;
    assign w_acc       = i_push && !r_valid;
    assign o_blk_valid = r_valid;
    assign o_blk       = '{words: r_words, reload: r_reload, variant: r_var, last: r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= r_count + 4'd1;
                if (r_count == 4'd15) begin
                    r_valid <= 1'b1;
                end
            end else if (i_blk_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_words[r_count*64 +: 64] <= i_word.message_word;
            if (r_count == 4'd0) begin
                r_reload <= i_word.first_block;
                r_var    <= i_variant;
            end
            if (r_count == 4'd15) begin
                r_last <= i_word.last_block;
            end
        end
    end
endmodule

// File: design/s512_engine.sv
module s512_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  s512_pkg::t_blk    i_blk,
    input  logic              i_blk_valid,
    output logic              o_blk_take,
    output s512_pkg::t_out_word o_word,
    output logic              o_empty,
    input  logic              i_pop
);
    import s512_pkg::*;

    t_eng_state    r_state, n_state;
    logic [511:0]  r_hash;
    logic [511:0]  r_v;
    logic [1023:0] r_w;
    logic [6:0]    r_t;
    logic [2:0]    r_idx;
    logic          r_last;

    logic [63:0] a, b, c, d, e, f, g, h, wt, w1, w14, w9, w0;
    logic [63:0] s0, s1, sg0, sg1, ch, maj, t1, t2, wnew;
    logic [511:0] w_base;

    assign a = r_v[63:0];      assign b = r_v[127:64];
    assign c = r_v[191:128];   assign d = r_v[255:192];
    assign e = r_v[319:256];   assign f = r_v[383:320];
    assign g = r_v[447:384];   assign h = r_v[511:448];

    // window holds w[t..t+15] with w[t] in the low word
    assign w0  = r_w[63:0];
    assign w1  = r_w[127:64];
    assign w9  = r_w[639:576];
    assign w14 = r_w[959:896];
    assign sg0 = {w1[0], w1[63:1]} ^ {w1[7:0], w1[63:8]} ^ (w1 >> 7);
    assign sg1 = {w14[18:0], w14[63:19]} ^ {w14[60:0], w14[63:61]} ^ (w14 >> 6);
    assign wnew = sg1 + w9 + sg0 + w0;
    assign wt  = w0;

    assign s1  = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
    assign ch  = (e & f) ^ (~e & g);
    assign t1  = h + s1 + ch + round_k(r_t) + wt;
    assign s0  = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
    assign maj = (a & b) ^ (a & c) ^ (b & c);
    assign t2  = s0 + maj;

    assign w_base = i_blk.reload ? init_hash(i_blk.variant) : r_hash;

    assign o_word = '{hash_word: r_hash[r_idx*64 +: 64], hash_index: r_idx,
                      final_word: (r_idx == 3'd7)};

    always_comb begin
        n_state    = r_state;
        o_blk_take = 1'b0;
        o_empty    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (i_blk_valid) begin
                    o_blk_take = 1'b1;
                    n_state    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_t == 7'(NumRounds - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_state = r_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                o_empty = 1'b0;
                if (i_pop && r_idx == 3'd7) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hash  <= init_hash(1'b0);
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (i_blk_valid) begin
                        r_hash <= w_base;
                    end
                    r_idx <= '0;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i*64 +: 64] <= r_hash[i*64 +: 64] + r_v[i*64 +: 64];
                    end
                end
                ST_EMIT: begin
                    if (i_pop) begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_blk_valid) begin
            r_v    <= w_base;
            r_w    <= i_blk.words;
            r_t    <= '0;
            r_last <= i_blk.last;
        end else if (r_state == ST_ROUND) begin
            r_v <= {g, f, e, d + t1, c, b, a, t1 + t2};
            r_w <= {wnew, r_w[1023:64]};
            r_t <= r_t + 7'd1;
        end
    end
endmodule

// File: design/sha512_block_compress_top.sv
// channel  | handshake        | payload
// input    | i_push / o_full  | i_in  (message_word, first_block, last_block)
// result   | o_empty / i_pop  | o_out (hash_word, hash_index, final_word)
// config   | i_cfg_valid / o_cfg_ready | i_cfg_data (variant)
//
// a word is taken each cycle while the collector has room; after the sixteenth
// word the block waits in the collector until the engine is idle and takes it,
// then the engine runs 80 rounds, one per cycle, and then the chaining add
// reset restores the sha-512 initial chaining value and clears the handshake state
// while the eight result words wait, the engine holds, and the collector can
// fill one further block before o_full rises
module sha512_block_compress_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  s512_pkg::t_in_word  i_in,
    input  logic                i_push,
    output logic                o_full,
    output s512_pkg::t_out_word o_out,
    output logic                o_empty,
    input  logic                i_pop,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);
    import s512_pkg::*;

    logic   r_variant;
    t_blk   w_blk;
    logic   w_blk_valid;
    logic   w_blk_take;

    // config register, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= 1'b0;
        end else if (i_cfg_valid) begin
            r_variant <= i_cfg_data;
        end
    end

    // word collector: the front side
    s512_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_in),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_variant   (r_variant),
        .o_blk       (w_blk),
        .o_blk_valid (w_blk_valid),
        .i_blk_take  (w_blk_take)
    );

    // round engine and result output: the back side
    s512_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk       (w_blk),
        .i_blk_valid (w_blk_valid),
        .o_blk_take  (w_blk_take),
        .o_word      (o_out),
        .o_empty     (o_empty),
        .i_pop       (i_pop)
    );

    // a block is only handed over while it is waiting
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_blk_take |-> w_blk_valid)
        else $error("block taken while none waits");
    // results walk in order: a popped word is followed by the next index
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !o_out.final_word) |=>
        (!o_empty && o_out.hash_index == $past(o_out.hash_index) + 3'd1))
        else $error("result index skipped");
    // final marker only on the last index
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_out.final_word == (o_out.hash_index == 3'd7)))
        else $error("final marker misplaced");
endmodule

// File: tb/tb_sha512_block_compress_top.sv
`timescale 1ns / 100ps

import s512_pkg::*;

// running sha-512 chaining value and the hash words it is expected to produce
class hash_scoreboard;
    logic [63:0] k_tab [80];
    logic [63:0] chain [8];
    logic [63:0] blk [16];
    logic [3:0]  word_pos;
    logic        variant;
    t_out_word   pending_words [$];
    int          errors;

    function new();
        k_tab = '{
            64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
            64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
            64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
            64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
            64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
            64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
            64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
            64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
            64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
            64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
            64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
            64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
            64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
            64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
            64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
            64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
            64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
            64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
            64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
            64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};
        variant = 1'b0;
        load_iv();
        word_pos = '0;
        errors = 0;
    endfunction

    function void load_iv();
        if (variant)
            chain = '{64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17,
                      64'h152FECD8F70E5939, 64'h67332667FFC00B31, 64'h8EB44A8768581511,
                      64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4};
        else
            chain = '{64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
                      64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
                      64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};
    endfunction

    function logic [63:0] rotr(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function void run_rounds();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] wt, x2, x15, t1, t2;
        w = blk;
        v = chain;
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                x2 = w[(t - 2) & 15];
                x15 = w[(t - 15) & 15];
                wt = (rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6)) + w[(t - 7) & 15]
                   + (rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7)) + w[t & 15];
                w[t & 15] = wt;
            end
            t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[t] + wt;
            t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--) v[i] = v[i - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    function void note_word(t_in_word wd);
        t_out_word o;
        if (word_pos == 0 && wd.first_block) load_iv();
        blk[word_pos] = wd.message_word;
        if (word_pos == 15) begin
            run_rounds();
            if (wd.last_block) begin
                for (int i = 0; i < 8; i++) begin
                    o.hash_word = chain[i];
                    o.hash_index = i[2:0];
                    o.final_word = (i == 7);
                    pending_words.push_back(o);
                end
            end
        end
        word_pos = word_pos + 4'd1;
    endfunction

    function void check_word(t_out_word got);
        t_out_word exp_w;
        if (pending_words.size() == 0) begin
            $display("%0t: unexpected hash word, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        exp_w = pending_words.pop_front();
        if (got.hash_word !== exp_w.hash_word) begin
            $display("%0t: hash_word mismatch, expected %h, actual %h",
                     $time, exp_w.hash_word, got.hash_word);
            errors++;
        end
        if (got.hash_index !== exp_w.hash_index) begin
            $display("%0t: hash_index mismatch, expected %0d, actual %0d",
                     $time, exp_w.hash_index, got.hash_index);
            errors++;
        end
        if (got.final_word !== exp_w.final_word) begin
            $display("%0t: final_word mismatch, expected %b, actual %b",
                     $time, exp_w.final_word, got.final_word);
            errors++;
        end
    endfunction
endclass

module tb_sha512_block_compress_top;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 200;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    t_in_word  i_in = '0;
    logic      i_push = 1'b0;
    logic      o_full;
    t_out_word o_out;
    logic      o_empty;
    logic      i_pop = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_data = 1'b0;

    hash_scoreboard hash_sb;
    int  cycle_count = 0;
    // hold-off controls: pop_hold for the result side, no_idle for both sides
    bit  pop_hold = 1'b0;
    bit  no_idle = 1'b0;

    sha512_block_compress_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_push      (i_push),
        .o_full      (o_full),
        .o_out       (o_out),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall bursts, a long hold-off on request, checks on accept
    initial begin
        int stall;
        hash_sb = new();
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) hash_sb.check_word(o_out);
            if (stall > 0) begin
                stall--;
                i_pop <= 1'b0;
            end else if (pop_hold) begin
                i_pop <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 18) - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // offer one word, optionally after a random idle burst; returns once accepted
    // push stays high afterwards so words can follow back to back
    task automatic push_word(input logic [63:0] data, input logic first, input logic last);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= '{message_word: data, first_block: first, last_block: last};
        i_push <= 1'b1;
        do @(posedge i_clk); while (o_full);
        hash_sb.note_word(i_in);
    endtask

    // sixteen words of one block; flags may also sit at the wrong positions
    task automatic push_block(input logic first, input logic last, input int pattern,
                              input bit stray_flags);
        logic [63:0] d;
        for (int i = 0; i < 16; i++) begin
            case (pattern)
                0: d = '0;
                1: d = '1;
                2: d = {2{32'hAAAA_5555}};
                default: d = {$urandom, $urandom};
            endcase
            push_word(d, (i == 0) ? first : (stray_flags ? 1'($urandom) : 1'b0),
                      (i == 15) ? last : (stray_flags ? 1'($urandom) : 1'b0));
        end
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        while (hash_sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // the write carries a single bit, the variant, and updates the scoreboard
    task automatic write_variant(input logic v);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        hash_sb.variant = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int n_blocks;
        bit var_swapped;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no first flag right after reset: carries the sha-512 initial value
        push_block(1'b0, 1'b1, 0, 1'b0);
        push_block(1'b1, 1'b1, 1, 1'b0);
        wait_drained();

        write_variant(1'b1);
        push_block(1'b1, 1'b0, 2, 1'b1);
        push_block(1'b0, 1'b1, 3, 1'b1);
        wait_drained();

        // long stall at the result side so the block fills up and holds o_full
        fork
            begin
                pop_hold = 1'b1;
                repeat (600) @(posedge i_clk);
                pop_hold = 1'b0;
            end
            begin
                for (int b = 0; b < 3; b++) push_block(1'b1, 1'b1, 3, 1'b0);
                i_push <= 1'b0;
            end
        join
        // sender pauses until everything has come back
        wait_drained();
        write_variant(1'b0);

        // random messages of one to three blocks, mostly well formed
        n_blocks = 0;
        var_swapped = 1'b0;
        while (n_blocks < 19) begin
            int len;
            len = $urandom_range(1, 3);
            if (!var_swapped && n_blocks >= 9) begin
                var_swapped = 1'b1;
                wait_drained();
                write_variant(1'($urandom));
            end
            if (n_blocks >= 15) no_idle = 1'b1;
            for (int b = 0; b < len; b++)
                push_block((b == 0) ? ($urandom_range(0, 9) != 0) : 1'b0,
                           (b == len - 1) ? ($urandom_range(0, 9) != 0) : 1'b0,
                           ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : 3,
                           $urandom_range(0, 3) == 0);
            n_blocks += len;
        end

        wait_drained();
        if (hash_sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sha512_block_compress_top.f
design/s512_pkg.sv
design/s512_front.sv
design/s512_engine.sv
design/sha512_block_compress_top.sv
tb/tb_sha512_block_compress_top.sv
